// ===== design/srhs_pkg.sv =====
// ----------------------------------------------------------------------------
// srhs_pkg: shared types and constants of the series relation hit scorer
// Holds the queue entry type, the scoring candidate type, register indexes
// and the pick function used by the selection stages.
// ----------------------------------------------------------------------------
`default_nettype none

package srhs_pkg;

  localparam int NUM_REL        = 5;
  localparam int MAX_POINTS_DEF = 65536;
  localparam int FIELD_CAP      = 65536;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

  localparam logic CFG_K_RATING     = 1'b0;
  localparam logic CFG_TARGET_TOTAL = 1'b1;

  localparam logic [2:0] REL_NONE = 3'd0;

  // Classified point as it travels from the front to the back.
  typedef struct packed {
    logic gt;
    logic lt;
    logic tgt;
    logic ntg;
    logic last;
  } point_class_t;

  // One relation under consideration for the best rating.
  typedef struct packed {
    logic               ok;
    logic [2:0]         rel;
    logic signed [32:0] rate;
    logic [16:0]        hits;
    logic [16:0]        fhits;
  } cand_t;

  // Keep the earlier candidate unless the later one rates strictly higher.
  function automatic cand_t pick(cand_t early, cand_t later);
    if (early.ok && (!later.ok || early.rate >= later.rate)) begin
      return early;
    end
    return later;
  endfunction

endpackage

`default_nettype wire

// ===== design/srhs_front.sv =====
// ----------------------------------------------------------------------------
// srhs_front: point intake and float comparison
// Accepts a request while the queue has room and classifies the pair of
// single precision values into greater and less flags.
// ----------------------------------------------------------------------------
`default_nettype none

module srhs_front import srhs_pkg::*; (
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [31:0]  in_value_a,
  input  wire logic [31:0]  in_value_b,
  input  wire logic         in_target_bit,
  input  wire logic         in_nontarget_bit,
  input  wire logic         in_last,
  input  wire logic         q_full,
  output logic              q_push,
  output point_class_t      q_entry
);

  function automatic logic is_nan(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  // Unsigned key whose order follows the numeric order; both zeros map alike.
  function automatic logic [31:0] order_key(logic [31:0] x);
    logic [31:0] z;
    z = (x[30:0] == 31'd0) ? 32'd0 : x;
    return z[31] ? ~z : {1'b1, z[30:0]};
  endfunction

  logic        ordered;
  logic [31:0] key_a;
  logic [31:0] key_b;

  assign ordered  = !is_nan(in_value_a) && !is_nan(in_value_b);
  assign key_a    = order_key(in_value_a);
  assign key_b    = order_key(in_value_b);
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry.gt   = ordered && (key_a > key_b);
    q_entry.lt   = ordered && (key_a < key_b);
    q_entry.tgt  = in_target_bit;
    q_entry.ntg  = in_nontarget_bit;
    q_entry.last = in_last;
  end

endmodule

`default_nettype wire

// ===== design/srhs_queue.sv =====
// ----------------------------------------------------------------------------
// srhs_queue: short queue between the front and the back
// A small circular buffer of classified points with full and valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module srhs_queue import srhs_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire point_class_t push_entry,
  output logic              full,
  input  wire logic         pop,
  output logic              valid,
  output point_class_t      head
);

  point_class_t        slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W:0]     count_r;
  logic                do_pop;

  assign full   = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid  = (count_r != '0);
  assign head   = slot_r[rd_ptr_r];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push && !full, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/srhs_back.sv =====
// ----------------------------------------------------------------------------
// srhs_back: hit counters and rating pipeline
// Counts target and non-target hits of the five relations, and on the last
// point scores them in a pipeline of multiply, subtract and two pick stages.
// ----------------------------------------------------------------------------
`default_nettype none

module srhs_back import srhs_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire point_class_t        q_head,
  output logic                     q_pop,
  input  wire logic [15:0]         k_rating,
  input  wire logic [16:0]         target_total,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_best_relation,
  output logic signed [32:0]       out_best_rating,
  output logic [16:0]              out_best_hits,
  output logic [16:0]              out_best_false_hits
);

  localparam logic [16:0] CountCap =
    17'((MAX_POINTS < FIELD_CAP) ? MAX_POINTS : FIELD_CAP);

  logic               hold;
  logic [NUM_REL-1:0] rel;
  logic [16:0]        hit_r   [NUM_REL];
  logic [16:0]        fhit_r  [NUM_REL];
  logic [16:0]        hit_nxt [NUM_REL];
  logic [16:0]        fhit_nxt[NUM_REL];

  logic               s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic [16:0]        s1_h_r  [NUM_REL];
  logic [16:0]        s1_f_r  [NUM_REL];
  logic [NUM_REL-1:0] s1_ok_r;
  logic [32:0]        s2_p_r  [NUM_REL];
  logic [16:0]        s2_h_r  [NUM_REL];
  logic [16:0]        s2_f_r  [NUM_REL];
  logic [NUM_REL-1:0] s2_ok_r;
  cand_t              s3_c_r  [NUM_REL];
  cand_t              s4_a_r, s4_b_r, s4_c_r;
  cand_t              best;

  // The whole scoring path stalls while a result waits to be taken.
  assign hold  = out_v_r && !out_ready;
  assign q_pop = q_valid && !hold;

  assign rel[0] = q_head.gt;
  assign rel[1] = q_head.lt;
  assign rel[2] = !q_head.lt;
  assign rel[3] = !q_head.gt;
  assign rel[4] = !q_head.gt && !q_head.lt;

  always_comb begin
    for (int i = 0; i < NUM_REL; i++) begin
      hit_nxt[i]  = hit_r[i];
      fhit_nxt[i] = fhit_r[i];
      if (rel[i] && q_head.tgt && (hit_r[i] < CountCap)) begin
        hit_nxt[i] = hit_r[i] + 17'd1;
      end
      if (rel[i] && q_head.ntg && (fhit_r[i] < CountCap)) begin
        fhit_nxt[i] = fhit_r[i] + 17'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REL; i++) begin
        hit_r[i]  <= '0;
        fhit_r[i] <= '0;
      end
    end else if (q_pop) begin
      for (int i = 0; i < NUM_REL; i++) begin
        hit_r[i]  <= q_head.last ? 17'd0 : hit_nxt[i];
        fhit_r[i] <= q_head.last ? 17'd0 : fhit_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (!hold) begin
      s1_v_r  <= q_pop && q_head.last;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      out_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      for (int i = 0; i < NUM_REL; i++) begin
        s1_h_r[i]  <= hit_nxt[i];
        s1_f_r[i]  <= fhit_nxt[i];
        s1_ok_r[i] <= (hit_nxt[i] != 17'd0) && (hit_nxt[i] < target_total);

        s2_p_r[i]  <= {16'd0, s1_h_r[i]} * {17'd0, k_rating};
        s2_h_r[i]  <= s1_h_r[i];
        s2_f_r[i]  <= s1_f_r[i];
        s2_ok_r[i] <= s1_ok_r[i];

        // The product stays below 2**32, so it fits the signed rating.
        s3_c_r[i].ok    <= s2_ok_r[i];
        s3_c_r[i].rel   <= 3'(i + 1);
        s3_c_r[i].rate  <= $signed(s2_p_r[i]) - $signed({8'd0, s2_f_r[i], 8'd0});
        s3_c_r[i].hits  <= s2_h_r[i];
        s3_c_r[i].fhits <= s2_f_r[i];
      end
      s4_a_r <= pick(s3_c_r[0], s3_c_r[1]);
      s4_b_r <= pick(s3_c_r[2], s3_c_r[3]);
      s4_c_r <= s3_c_r[4];
      if (best.ok) begin
        out_best_relation   <= best.rel;
        out_best_rating     <= best.rate;
        out_best_hits       <= best.hits;
        out_best_false_hits <= best.fhits;
      end else begin
        out_best_relation   <= REL_NONE;
        out_best_rating     <= '0;
        out_best_hits       <= '0;
        out_best_false_hits <= '0;
      end
    end
  end

  assign best      = pick(pick(s4_a_r, s4_b_r), s4_c_r);
  assign out_valid = out_v_r;

endmodule

`default_nettype wire

// ===== design/series_relation_hit_scorer.sv =====
// ----------------------------------------------------------------------------
// series_relation_hit_scorer: relation hit counting and rating of a series
// Compares float pairs point by point, counts hits of five relations and
// reports the best certified relation on the last point of a series.
// ----------------------------------------------------------------------------
//   channel  direction  handshake             carries
//   in_      input      in_valid / in_ready   value pair, target, nontarget, last
//   out_     output     out_valid / out_ready best relation, rating, hit counts
//   cfg_     input      cfg_we                k_rating, target_total
//
// One point is accepted per cycle while the queue has room; the front compares
// and queues it, the back pops one queue entry per cycle unless a result is
// stalled, to update the counters. A result passes from its last point through
// multiply, subtract and two selection stages. Reset clears the counters and
// loads k_rating with 1.0. A stalled result freezes the back; the four-entry
// queue absorbs input until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module series_relation_hit_scorer import srhs_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [16:0]         cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [31:0]         in_value_a,
  input  wire logic [31:0]         in_value_b,
  input  wire logic                in_target_bit,
  input  wire logic                in_nontarget_bit,
  input  wire logic                in_last,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_best_relation,
  output logic signed [32:0]       out_best_rating,
  output logic [16:0]              out_best_hits,
  output logic [16:0]              out_best_false_hits
);

  logic [15:0]  k_rating_r;
  logic [16:0]  target_total_r;
  logic         q_full, q_push, q_valid, q_pop;
  point_class_t q_in, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_rating_r     <= 16'd256;
      target_total_r <= 17'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_K_RATING:     k_rating_r     <= cfg_wdata[15:0];
        CFG_TARGET_TOTAL: target_total_r <= cfg_wdata;
        default:          k_rating_r     <= k_rating_r;
      endcase
    end
  end

  srhs_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value_a       (in_value_a),
    .in_value_b       (in_value_b),
    .in_target_bit    (in_target_bit),
    .in_nontarget_bit (in_nontarget_bit),
    .in_last          (in_last),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (q_in)
  );

  srhs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  srhs_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .k_rating            (k_rating_r),
    .target_total        (target_total_r),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_best_relation   (out_best_relation),
    .out_best_rating     (out_best_rating),
    .out_best_hits       (out_best_hits),
    .out_best_false_hits (out_best_false_hits)
  );

endmodule

`default_nettype wire

// ===== verif/series_relation_hit_scorer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// series_relation_hit_scorer_tb: self-checking bench for the relation scorer
// Streams float pairs with target and non-target bits through the block,
// predicts the relation counters and the best certified relation of every
// series, and compares each result field by field against that prediction.
// ----------------------------------------------------------------------------

module series_relation_hit_scorer_tb;

  localparam int COUNT_CAP = (srhs_pkg::MAX_POINTS_DEF < srhs_pkg::FIELD_CAP) ?
                             srhs_pkg::MAX_POINTS_DEF : srhs_pkg::FIELD_CAP;

  localparam logic [31:0] F_POS_ZERO = 32'h0000_0000;
  localparam logic [31:0] F_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] F_ONE      = 32'h3F80_0000;
  localparam logic [31:0] F_HALF     = 32'h3F00_0000;
  localparam logic [31:0] F_TWO      = 32'h4000_0000;
  localparam logic [31:0] F_NEG_ONE  = 32'hBF80_0000;
  localparam logic [31:0] F_MAX      = 32'h7F7F_FFFF;
  localparam logic [31:0] F_POS_INF  = 32'h7F80_0000;
  localparam logic [31:0] F_NEG_INF  = 32'hFF80_0000;
  localparam logic [31:0] F_QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] F_SNAN     = 32'h7F80_0001;
  localparam logic [31:0] F_NEG_NAN  = 32'hFFFF_FFFF;
  localparam logic [31:0] F_MIN_SUB  = 32'h0000_0001;
  localparam logic [31:0] F_NEG_SUB  = 32'h8000_0001;

  typedef enum logic [2:0] {
    RELATION_NONE   = 3'd0,
    RELATION_GT     = 3'd1,
    RELATION_LT     = 3'd2,
    RELATION_NOT_LT = 3'd3,
    RELATION_NOT_GT = 3'd4,
    RELATION_EQ     = 3'd5
  } relation_e;

  typedef struct packed {
    logic [2:0]  relation;
    logic [32:0] rating;
    logic [16:0] hits;
    logic [16:0] false_hits;
  } score_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = srhs_pkg::CFG_K_RATING;
  logic [16:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_value_a = '0;
  logic [31:0] in_value_b = '0;
  logic in_target_bit = 1'b0;
  logic in_nontarget_bit = 1'b0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_best_relation;
  logic signed [32:0] out_best_rating;
  logic [16:0] out_best_hits;
  logic [16:0] out_best_false_hits;

  // Mirror of the block's counters and registers.
  logic [16:0] hit_cnt [5];
  logic [16:0] false_cnt [5];
  logic [15:0] k_weight = 16'd256;
  logic [16:0] total_targets = '0;

  score_t pending_scores [$];
  score_t want;
  int fail_count = 0;
  bit idle_enabled = 1'b1;

  series_relation_hit_scorer uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_value_a          (in_value_a),
    .in_value_b          (in_value_b),
    .in_target_bit       (in_target_bit),
    .in_nontarget_bit    (in_nontarget_bit),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_best_relation   (out_best_relation),
    .out_best_rating     (out_best_rating),
    .out_best_hits       (out_best_hits),
    .out_best_false_hits (out_best_false_hits)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= !(idle_enabled && $urandom_range(0, 99) < 10);
  end

  function automatic bit is_nan_pattern(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != '0);
  endfunction

  // Unsigned key whose order follows the numeric order; both zeros map alike.
  function automatic logic [31:0] sort_key(logic [31:0] x);
    if (x[30:0] == '0) begin
      x = '0;
    end
    return x[31] ? ~x : {1'b1, x[30:0]};
  endfunction

  function automatic void clear_counts();
    for (int i = 0; i < 5; i++) begin
      hit_cnt[i] = '0;
      false_cnt[i] = '0;
    end
  endfunction

  function automatic void score_point(logic [31:0] a, logic [31:0] b,
                                      bit tgt, bit ntg, bit is_last);
    logic gt;
    logic lt;
    logic [4:0] holds;
    int best;
    longint best_rate;
    longint rate;
    score_t s;
    gt = 1'b0;
    lt = 1'b0;
    if (!is_nan_pattern(a) && !is_nan_pattern(b)) begin
      gt = sort_key(a) > sort_key(b);
      lt = sort_key(a) < sort_key(b);
    end
    holds = {!gt && !lt, !gt, !lt, lt, gt};
    for (int i = 0; i < 5; i++) begin
      if (holds[i]) begin
        if (tgt && hit_cnt[i] < COUNT_CAP) hit_cnt[i]++;
        if (ntg && false_cnt[i] < COUNT_CAP) false_cnt[i]++;
      end
    end
    if (!is_last) return;
    best = -1;
    best_rate = 0;
    for (int i = 0; i < 5; i++) begin
      if (hit_cnt[i] != '0 && hit_cnt[i] < total_targets) begin
        rate = longint'(hit_cnt[i]) * longint'(k_weight) - longint'(false_cnt[i]) * 256;
        // Only a strictly higher rating displaces an earlier relation.
        if (best < 0 || rate > best_rate) begin
          best = i;
          best_rate = rate;
        end
      end
    end
    s = '0;
    s.relation = RELATION_NONE;
    if (best >= 0) begin
      s.relation = relation_e'(best + 1);
      s.rating = best_rate[32:0];
      s.hits = hit_cnt[best];
      s.false_hits = false_cnt[best];
    end
    pending_scores.insert(pending_scores.size(), s);
    clear_counts();
  endfunction

  task automatic send_point(logic [31:0] a, logic [31:0] b, bit tgt, bit ntg, bit is_last);
    while (idle_enabled && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value_a <= a;
    in_value_b <= b;
    in_target_bit <= tgt;
    in_nontarget_bit <= ntg;
    in_last <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    score_point(a, b, tgt, ntg, is_last);
  endtask

  // Lowers valid, waits for every predicted result and lets the pipeline settle.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_scores.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_scores.size() != 0) begin
      $error("%0d expected results never arrived", pending_scores.size());
      fail_count++;
      pending_scores.delete();
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [16:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == srhs_pkg::CFG_K_RATING) begin
      k_weight = data[15:0];
    end else begin
      total_targets = data;
    end
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 6))
      0: v = $urandom;
      1: v = {v[31], 8'h00, v[22:0]};
      2: v = {v[31], 8'hFF, v[22:1], 1'b1};
      3: v = {v[31], 8'd126 + 8'($urandom_range(0, 2)), v[22:0]};
      4: v = v[0] ? F_POS_INF : F_NEG_INF;
      5: v = v[0] ? F_POS_ZERO : F_NEG_ZERO;
      default: v = {v[31], 8'd127, 20'd0, v[2:0]};
    endcase
    return v;
  endfunction

  task automatic test_reset_defaults();
    // With target_total at its reset value of zero nothing can be certified.
    send_point(F_ONE, F_HALF, 1'b1, 1'b0, 1'b0);
    send_point(F_HALF, F_ONE, 1'b1, 1'b1, 1'b1);
    drain_results();
  endtask

  task automatic test_special_values();
    write_reg(srhs_pkg::CFG_K_RATING, 17'd256);
    write_reg(srhs_pkg::CFG_TARGET_TOTAL, 17'd100);
    send_point(F_ONE, F_HALF, 1'b1, 1'b0, 1'b0);
    send_point(F_TWO, F_NEG_ONE, 1'b1, 1'b0, 1'b0);
    send_point(F_POS_INF, F_MAX, 1'b1, 1'b1, 1'b0);
    send_point(32'h0000_0002, F_MIN_SUB, 1'b1, 1'b0, 1'b0);
    send_point(F_NEG_ZERO, F_POS_ZERO, 1'b0, 1'b1, 1'b1);
    // NaN on either side counts as equal, never as greater or less.
    send_point(F_QNAN, F_ONE, 1'b1, 1'b0, 1'b0);
    send_point(F_ONE, F_NEG_NAN, 1'b1, 1'b1, 1'b0);
    send_point(F_SNAN, F_SNAN, 1'b0, 1'b0, 1'b0);
    send_point(F_NEG_INF, F_NEG_SUB, 1'b1, 1'b0, 1'b0);
    send_point(F_NEG_SUB, F_MIN_SUB, 1'b1, 1'b0, 1'b1);
    send_point(F_ONE, F_ONE, 1'b1, 1'b1, 1'b1);
    send_point(F_MAX, F_MIN_SUB, 1'b0, 1'b0, 1'b1);
    // Equal pairs tie three relations; not-less comes first in the scan.
    send_point(F_POS_ZERO, F_NEG_ZERO, 1'b1, 1'b0, 1'b0);
    send_point(F_TWO, F_TWO, 1'b1, 1'b0, 1'b1);
    drain_results();
  endtask

  task automatic test_config_extremes();
    logic [15:0] k_set [4];
    logic [16:0] total_set [4];
    k_set = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd256};
    total_set = '{17'd65536, 17'd65536, 17'd1, 17'd2};
    for (int i = 0; i < 4; i++) begin
      write_reg(srhs_pkg::CFG_K_RATING, {1'b0, k_set[i]});
      write_reg(srhs_pkg::CFG_TARGET_TOTAL, total_set[i]);
      send_point(F_TWO, F_ONE, 1'b1, 1'b0, 1'b0);
      send_point(F_HALF, F_ONE, 1'b1, 1'b1, 1'b0);
      send_point(F_ONE, F_ONE, 1'b1, 1'b0, 1'b1);
      drain_results();
    end
  endtask

  task automatic test_negative_rating();
    // With a zero hit weight every false hit pulls the rating below zero.
    write_reg(srhs_pkg::CFG_K_RATING, 17'd0);
    write_reg(srhs_pkg::CFG_TARGET_TOTAL, 17'd65536);
    for (int i = 0; i < 40; i++) begin
      send_point(F_ONE, F_TWO, i < 10, 1'b1, i == 39);
    end
    drain_results();
  endtask

  task automatic test_random_series();
    int sent;
    int len;
    logic [15:0] k_val;
    logic [16:0] total_val;
    logic [31:0] a;
    logic [31:0] b;
    for (int phase = 0; phase < 6; phase++) begin
      idle_enabled = (phase != 2);
      k_val = 16'($urandom);
      case (phase)
        0: total_val = 17'($urandom_range(2, 20));
        1: begin
          k_val = 16'hFFFF;
          total_val = 17'($urandom_range(1, 40));
        end
        2: begin
          k_val = 16'd0;
          total_val = 17'd65536;
        end
        3: begin
          k_val = 16'($urandom_range(128, 512));
          total_val = 17'($urandom_range(5, 15));
        end
        4: total_val = '0;
        default: total_val = 17'($urandom_range(0, 65536));
      endcase
      write_reg(srhs_pkg::CFG_K_RATING, {1'b0, k_val});
      write_reg(srhs_pkg::CFG_TARGET_TOTAL, total_val);
      sent = 0;
      while (sent < 80) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 40) : $urandom_range(1, 20);
        for (int j = 0; j < len; j++) begin
          a = random_float();
          case ($urandom_range(0, 4))
            0, 1: b = random_float();
            2: b = a;
            3: b = a ^ 32'h8000_0000;
            default: b = a + 32'd1;
          endcase
          send_point(a, b, $urandom_range(0, 9) < 6, $urandom_range(0, 9) < 4, j == len - 1);
        end
        sent += len;
      end
      drain_results();
    end
    idle_enabled = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_scores.size() == 0) begin
        $error("result arrived with no series outstanding");
        fail_count++;
      end else begin
        want = pending_scores.pop_front();
        if (out_best_relation !== want.relation) begin
          $error("best_relation: expected %0d, got %0d", want.relation, out_best_relation);
          fail_count++;
        end
        if (out_best_rating !== want.rating) begin
          $error("best_rating: expected %0d, got %0d",
                 $signed(want.rating), out_best_rating);
          fail_count++;
        end
        if (out_best_hits !== want.hits) begin
          $error("best_hits: expected %0d, got %0d", want.hits, out_best_hits);
          fail_count++;
        end
        if (out_best_false_hits !== want.false_hits) begin
          $error("best_false_hits: expected %0d, got %0d",
                 want.false_hits, out_best_false_hits);
          fail_count++;
        end
      end
    end
  end

  initial begin
    clear_counts();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_special_values();
    test_config_extremes();
    test_negative_rating();
    test_random_series();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
design/srhs_pkg.sv
design/srhs_front.sv
design/srhs_queue.sv
design/srhs_back.sv
design/series_relation_hit_scorer.sv
verif/series_relation_hit_scorer_tb.sv
